@@ rtl/core/ubss_pkg.sv @@
package ubss_pkg;

    localparam int unsigned DIVISOR_BITS = 12;

    localparam int unsigned CLK_W   = 30;
    localparam int unsigned BAUD_W  = 24;
    localparam int unsigned DIV_W   = DIVISOR_BITS;
    localparam int unsigned SCALE_W = 5;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned D_W     = BAUD_W + 4;
    localparam int unsigned Q_W     = CLK_W + FRAC_W;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned T_W     = 4;
    localparam int unsigned OFF_W   = 8;
    localparam int unsigned PC_W    = 4;

    localparam logic [CNT_W-1:0]   DIV_STEPS  = CNT_W'(Q_W);
    localparam logic [T_W-1:0]     T_END      = 4'd15;
    localparam logic [OFF_W-1:0]   OFF_START  = 8'd128;
    localparam logic [SCALE_W-1:0] SCALE_BIAS = 5'd7;
    localparam logic [SCALE_W-1:0] SCALE_NONE = 5'd8;

    typedef struct packed {
        logic [CLK_W-1:0]  clock_hz;
        logic [BAUD_W-1:0] baud_rate;
        logic              double_speed;
    } in_t;

    typedef struct packed {
        logic signed [SCALE_W-1:0] scale;
        logic [DIV_W-1:0]          divisor;
        logic                      ok;
    } out_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV,
        OP_SINIT,
        OP_SRCH,
        OP_NONE,
        OP_FOUND,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_D_ZERO,
        C_DIV_MORE,
        C_FIT,
        C_MORE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic d_zero;
        logic div_more;
        logic fit;
        logic more;
        logic out_free;
    } status_t;

    localparam logic [PC_W-1:0] STEP_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] STEP_CHECK = 4'd1;
    localparam logic [PC_W-1:0] STEP_DIV   = 4'd2;
    localparam logic [PC_W-1:0] STEP_SINIT = 4'd3;
    localparam logic [PC_W-1:0] STEP_SRCH  = 4'd4;
    localparam logic [PC_W-1:0] STEP_NEXT  = 4'd5;
    localparam logic [PC_W-1:0] STEP_NONE  = 4'd6;
    localparam logic [PC_W-1:0] STEP_FOUND = 4'd7;
    localparam logic [PC_W-1:0] STEP_EMIT  = 4'd8;
    localparam logic [PC_W-1:0] STEP_RETRY = 4'd9;

    // jump to target when the condition holds, otherwise fall through
    function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        unique case (pc)
            STEP_WAIT:  w = '{op: OP_ACCEPT, cond: C_NO_IN,     target: STEP_WAIT};
            STEP_CHECK: w = '{op: OP_NOP,    cond: C_D_ZERO,    target: STEP_NONE};
            STEP_DIV:   w = '{op: OP_DIV,    cond: C_DIV_MORE,  target: STEP_DIV};
            STEP_SINIT: w = '{op: OP_SINIT,  cond: C_NEVER,     target: STEP_WAIT};
            STEP_SRCH:  w = '{op: OP_SRCH,   cond: C_FIT,       target: STEP_FOUND};
            STEP_NEXT:  w = '{op: OP_NOP,    cond: C_MORE,      target: STEP_SRCH};
            STEP_NONE:  w = '{op: OP_NONE,   cond: C_ALWAYS,    target: STEP_EMIT};
            STEP_FOUND: w = '{op: OP_FOUND,  cond: C_NEVER,     target: STEP_WAIT};
            STEP_EMIT:  w = '{op: OP_EMIT,   cond: C_OUT_FREE,  target: STEP_WAIT};
            STEP_RETRY: w = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_EMIT};
            default:    w = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/ubss_datapath.sv @@
module ubss_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ubss_pkg::ctrl_word_t ctrl,
    input  logic                 in_fire,
    input  ubss_pkg::in_t        in_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output ubss_pkg::out_t       m_data,
    output ubss_pkg::status_t    status
);

    localparam int unsigned Q_W   = ubss_pkg::Q_W;
    localparam int unsigned D_W   = ubss_pkg::D_W;
    localparam int unsigned DIV_W = ubss_pkg::DIV_W;
    localparam logic [Q_W:0]       LIMIT = (Q_W + 1)'(1) << ubss_pkg::DIVISOR_BITS;
    localparam logic [DIV_W-1:0]   SAT   = DIV_W'(LIMIT - (Q_W + 1)'(1));

    logic [D_W-1:0]                  d_reg, d_next;
    logic [D_W-1:0]                  rem_reg, rem_next;
    logic [Q_W-1:0]                  acc_reg, acc_next;
    logic [ubss_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ubss_pkg::T_W-1:0]        t_reg, t_next;
    logic [ubss_pkg::OFF_W-1:0]      off_reg, off_next;
    ubss_pkg::out_t                  res_reg, res_next;
    logic                            m_valid_reg, m_valid_next;
    ubss_pkg::out_t                  m_data_reg, m_data_next;

    logic [D_W:0]   trial;
    logic [D_W:0]   trial_sub;
    logic           trial_ge;
    logic [Q_W-1:0] rnd;
    logic [Q_W:0]   off_ext;
    logic           fit;
    logic           neg;
    logic [Q_W-1:0] v;
    logic           out_free;

    always_comb begin
        // restoring divider, one quotient bit a step
        trial     = {rem_reg, acc_reg[Q_W-1]};
        trial_sub = trial - {1'b0, d_reg};
        trial_ge  = trial >= {1'b0, d_reg};

        // round half up of the scaled quotient at this shift
        rnd      = Q_W'(({1'b0, acc_reg} + (Q_W + 1)'(1)) >> 1);
        off_ext  = (Q_W + 1)'(off_reg);
        fit      = {1'b0, rnd} < (LIMIT + off_ext);
        neg      = {1'b0, rnd} < off_ext;
        v        = rnd - Q_W'(off_reg);
        out_free = !m_valid_reg || m_ready;

        status.d_zero   = d_reg == '0;
        status.div_more = cnt_reg != ubss_pkg::CNT_W'(1);
        status.fit      = fit;
        status.more     = t_reg != ubss_pkg::T_END;
        status.out_free = out_free;
    end

    always_comb begin
        d_next       = d_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        t_next       = t_reg;
        off_next     = off_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (ctrl.op)
            ubss_pkg::OP_ACCEPT: begin
                if (in_fire) begin
                    d_next   = in_data.double_speed ? {1'b0, in_data.baud_rate, 3'b000}
                                                    : {in_data.baud_rate, 4'b0000};
                    rem_next = '0;
                    acc_next = {in_data.clock_hz, ubss_pkg::FRAC_W'(0)};
                    cnt_next = ubss_pkg::DIV_STEPS;
                end
            end
            ubss_pkg::OP_DIV: begin
                rem_next = trial_ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
                acc_next = {acc_reg[Q_W-2:0], trial_ge};
                cnt_next = cnt_reg - ubss_pkg::CNT_W'(1);
            end
            ubss_pkg::OP_SINIT: begin
                t_next   = '0;
                off_next = ubss_pkg::OFF_START;
            end
            ubss_pkg::OP_SRCH: begin
                if (!fit) begin
                    acc_next = acc_reg >> 1;
                    t_next   = t_reg + ubss_pkg::T_W'(1);
                    // offset halves down to one and stays there for scale zero and up
                    off_next = (off_reg == ubss_pkg::OFF_W'(1)) ? off_reg : (off_reg >> 1);
                end
            end
            ubss_pkg::OP_NONE: begin
                res_next.scale   = ubss_pkg::SCALE_NONE;
                res_next.divisor = SAT;
                res_next.ok      = 1'b0;
            end
            ubss_pkg::OP_FOUND: begin
                res_next.scale   = {1'b0, t_reg} - ubss_pkg::SCALE_BIAS;
                res_next.divisor = neg ? '0 : v[DIV_W-1:0];
                res_next.ok      = !neg;
            end
            ubss_pkg::OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            ubss_pkg::OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg      <= d_next;
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        t_reg      <= t_next;
        off_reg    <= off_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/uart_baud_scale_select.sv @@
// Baud scale and divisor selection for a fractional-baud serial port.
// Input channel s_*: one beat carries clock_hz, baud_rate and double_speed.
// Result channel m_*: one beat per input with scale, divisor and ok.
// A small microcode program steps a shared datapath: accept, a 38-step
// restoring divide of clock_hz*256 by 8 or 16 times baud_rate, then a
// search over scales -7..7 in the program's search and next steps.
// A zero baud rate skips the divide and the search and goes from the
// check step straight to the no-fit result. The next input beat can be
// taken in the cycle after the result is loaded into the output
// register, so one item is in work at a time.
// If the receiver stalls, the finished result waits in the output
// register; a second result waits in the program's emit step until the
// first is taken, and no input is taken meanwhile.
// Synchronous active-low reset returns the program to its wait step and
// drops m_valid; no other state needs clearing.
module uart_baud_scale_select (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ubss_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ubss_pkg::out_t m_data
);

    logic [ubss_pkg::PC_W-1:0] pc_reg, pc_next;
    ubss_pkg::ctrl_word_t      word;
    ubss_pkg::status_t         status;
    logic                      take;

    always_comb begin
        word    = ubss_pkg::rom_word(pc_reg);
        s_ready = word.op == ubss_pkg::OP_ACCEPT;

        unique case (word.cond)
            ubss_pkg::C_NEVER:    take = 1'b0;
            ubss_pkg::C_ALWAYS:   take = 1'b1;
            ubss_pkg::C_NO_IN:    take = !s_valid;
            ubss_pkg::C_D_ZERO:   take = status.d_zero;
            ubss_pkg::C_DIV_MORE: take = status.div_more;
            ubss_pkg::C_FIT:      take = status.fit;
            ubss_pkg::C_MORE:     take = status.more;
            ubss_pkg::C_OUT_FREE: take = status.out_free;
            default:              take = 1'b0;
        endcase

        pc_next = take ? word.target : (pc_reg + ubss_pkg::PC_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ubss_pkg::STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    ubss_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (word),
        .in_fire (s_valid && s_ready),
        .in_data (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .status  (status)
    );

endmodule
